/* hw/rtl/bfi_pkg.sv */
`default_nettype none
package bfi_pkg;

	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_RBR   = 8'h5D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_BAD  = 3'd2;
	localparam logic [2:0] ST_OPEN = 3'd3;
	localparam logic [2:0] ST_NEST = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LOAD,
		S_BCLR,
		S_BRD,
		S_BDEC,
		S_BPOP,
		S_BPOP2,
		S_BEND,
		S_SRD,
		S_SEX,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic init_clr;
		logic match_clr;
		logic sweep_rst;
		logic load;
		logic build_init;
		logic walk_rd;
		logic walk_dec;
		logic pop_a;
		logic pop_b;
		logic build_end;
		logic step_rd;
		logic step_ex;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic match_last;
		logic item_cmd;
		logic item_last;
		logic walk_end;
		logic dec_open;
		logic dec_close;
		logic nest_full;
		logic slot_free;
	} stat_t;

endpackage
`default_nettype wire

/* hw/rtl/bfi_intf.sv */
`default_nettype none
interface bfi_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] prog_byte;
	logic       load_last;
	logic [7:0] in_byte;
	modport source(output valid, cmd, prog_byte, load_last, in_byte, input ready);
	modport sink(input valid, cmd, prog_byte, load_last, in_byte, output ready);
endinterface

interface bfi_out_if;
	logic        valid;
	logic        ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic [2:0]  status;
	logic [11:0] prog_counter;
	modport source(output valid, out_valid, out_byte, status, prog_counter, input ready);
	modport sink(input valid, out_valid, out_byte, status, prog_counter, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bfi_ctrl.sv */
`default_nettype none
module bfi_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  bfi_pkg::stat_t    stat,
	output bfi_pkg::cmd_t     cmd
);

	bfi_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfi_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfi_pkg::S_CLR: begin
				if (stat.init_last) state_d = bfi_pkg::S_IDLE;
			end
			bfi_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (stat.item_cmd == bfi_pkg::CMD_STEP) ? bfi_pkg::S_SRD
						: bfi_pkg::S_LOAD;
				end
			end
			bfi_pkg::S_LOAD: begin
				state_d = stat.item_last ? bfi_pkg::S_BCLR : bfi_pkg::S_OUT;
			end
			bfi_pkg::S_BCLR: begin
				if (stat.match_last) state_d = bfi_pkg::S_BRD;
			end
			bfi_pkg::S_BRD: begin
				state_d = stat.walk_end ? bfi_pkg::S_BEND : bfi_pkg::S_BDEC;
			end
			bfi_pkg::S_BDEC: begin
				if (stat.dec_open && stat.nest_full) state_d = bfi_pkg::S_OUT;
				else if (stat.dec_close) state_d = bfi_pkg::S_BPOP;
				else state_d = bfi_pkg::S_BRD;
			end
			bfi_pkg::S_BPOP:  state_d = bfi_pkg::S_BPOP2;
			bfi_pkg::S_BPOP2: state_d = bfi_pkg::S_BRD;
			bfi_pkg::S_BEND:  state_d = bfi_pkg::S_OUT;
			bfi_pkg::S_SRD:   state_d = bfi_pkg::S_SEX;
			bfi_pkg::S_SEX:   state_d = bfi_pkg::S_OUT;
			bfi_pkg::S_OUT: begin
				if (stat.slot_free) state_d = bfi_pkg::S_IDLE;
			end
			default: state_d = bfi_pkg::S_CLR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bfi_pkg::S_CLR:  cmd.init_clr = 1'b1;
			bfi_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			bfi_pkg::S_LOAD: begin
				cmd.load       = 1'b1;
				cmd.sweep_rst  = 1'b1;
				cmd.build_init = stat.item_last;
			end
			bfi_pkg::S_BCLR:  cmd.match_clr = 1'b1;
			bfi_pkg::S_BRD:   cmd.walk_rd = ~stat.walk_end;
			bfi_pkg::S_BDEC:  cmd.walk_dec = 1'b1;
			bfi_pkg::S_BPOP:  cmd.pop_a = 1'b1;
			bfi_pkg::S_BPOP2: cmd.pop_b = 1'b1;
			bfi_pkg::S_BEND:  cmd.build_end = 1'b1;
			bfi_pkg::S_SRD:   cmd.step_rd = 1'b1;
			bfi_pkg::S_SEX:   cmd.step_ex = 1'b1;
			bfi_pkg::S_OUT:   cmd.push = stat.slot_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/bfi_dpath.sv */
`default_nettype none
module bfi_dpath #(
	parameter int PROG_DEPTH = 4096,
	parameter int TAPE_DEPTH = 32768,
	parameter int NEST_DEPTH = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	input  bfi_pkg::cmd_t    cmd,
	output bfi_pkg::stat_t   stat,
	input  wire              in_cmd,
	input  wire  [7:0]       in_prog_byte,
	input  wire              in_load_last,
	input  wire  [7:0]       in_in_byte,
	input  wire              out_ready,
	output logic             out_valid,
	output logic             out_out_valid,
	output logic [7:0]       out_out_byte,
	output logic [2:0]       out_status,
	output logic [11:0]      out_prog_counter
);

	localparam int AW    = $clog2(PROG_DEPTH);
	localparam int TW    = $clog2(TAPE_DEPTH);
	localparam int SW    = $clog2(NEST_DEPTH);
	localparam int CLR_N = (TAPE_DEPTH > PROG_DEPTH) ? TAPE_DEPTH : PROG_DEPTH;
	localparam int CW    = $clog2(CLR_N) + 1;

	logic [7:0]    prog_mem  [PROG_DEPTH];
	logic [AW-1:0] match_mem [PROG_DEPTH];
	logic [7:0]    tape_mem  [TAPE_DEPTH];
	logic [AW-1:0] stk_mem   [NEST_DEPTH];

	logic          it_last_q;
	logic [7:0]    it_byte_q, it_in_q;
	logic [AW:0]   len_q, pc_q, wa_q;
	logic [TW-1:0] tp_q;
	logic [SW:0]   top_q;
	logic [CW-1:0] sc_q;
	logic [2:0]    err_q;
	logic          full_q;

	logic [7:0]    prog_rd_q, tape_rd_q;
	logic [AW-1:0] match_rd_q, stk_rd_q;

	logic          r_ov_q;
	logic [7:0]    r_ob_q;
	logic [2:0]    r_st_q;
	logic [11:0]   r_pc_q;
	logic          ov_q;

	// sweep address decode
	logic init_tape, init_match;
	assign init_tape  = cmd.init_clr && (sc_q < CW'(TAPE_DEPTH));
	assign init_match = cmd.init_clr && (sc_q < CW'(PROG_DEPTH));

	logic          load_full;
	logic [AW:0]   len_next;
	assign load_full = (len_q == (AW+1)'(PROG_DEPTH));
	assign len_next  = load_full ? len_q : len_q + 1'b1;

	logic          dec_open, dec_close, nest_full, push_en;
	logic [SW:0]   top_m1;
	assign dec_open  = (prog_rd_q == bfi_pkg::CH_LBR);
	assign dec_close = (prog_rd_q == bfi_pkg::CH_RBR) && (top_q != '0);
	assign nest_full = (top_q >= (SW+1)'(NEST_DEPTH));
	assign push_en   = cmd.walk_dec && dec_open && !nest_full;
	assign top_m1    = top_q - 1'b1;

	// step execute
	logic [AW:0]   nx_pc;
	logic [TW-1:0] nx_tp;
	logic          tw_en, set_bad, ex_ov;
	logic [7:0]    tw_d, ex_ob;
	logic [2:0]    ex_st;
	logic [AW:0]   jmp;
	assign jmp = {1'b0, match_rd_q} + 1'b1;

	always_comb begin
		nx_pc   = pc_q + 1'b1;
		nx_tp   = tp_q;
		tw_en   = 1'b0;
		tw_d    = tape_rd_q;
		set_bad = 1'b0;
		ex_ov   = 1'b0;
		ex_ob   = 8'd0;
		ex_st   = bfi_pkg::ST_OK;
		if (err_q != bfi_pkg::ST_OK) begin
			ex_st = err_q;
			nx_pc = pc_q;
		end else if (pc_q >= len_q) begin
			ex_st = bfi_pkg::ST_HALT;
			nx_pc = pc_q;
		end else begin
			case (prog_rd_q)
				bfi_pkg::CH_GT: begin
					nx_tp = (tp_q == TW'(TAPE_DEPTH - 1)) ? '0 : tp_q + 1'b1;
				end
				bfi_pkg::CH_LT: begin
					nx_tp = (tp_q == '0) ? TW'(TAPE_DEPTH - 1) : tp_q - 1'b1;
				end
				bfi_pkg::CH_PLUS: begin
					tw_en = 1'b1;
					tw_d  = tape_rd_q + 8'd1;
				end
				bfi_pkg::CH_MINUS: begin
					tw_en = 1'b1;
					tw_d  = tape_rd_q - 8'd1;
				end
				bfi_pkg::CH_DOT: begin
					ex_ov = 1'b1;
					ex_ob = tape_rd_q;
				end
				bfi_pkg::CH_COMMA: begin
					tw_en = 1'b1;
					tw_d  = it_in_q;
				end
				bfi_pkg::CH_LBR: begin
					if (tape_rd_q == 8'd0) nx_pc = jmp;
				end
				bfi_pkg::CH_RBR: begin
					if (tape_rd_q != 8'd0) nx_pc = jmp;
				end
				default: begin
					set_bad = 1'b1;
					ex_st   = bfi_pkg::ST_BAD;
					nx_pc   = pc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			it_byte_q <= in_prog_byte;
			it_last_q <= in_load_last;
			it_in_q   <= in_in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pc_q   <= '0;
			wa_q   <= '0;
			tp_q   <= '0;
			top_q  <= '0;
			sc_q   <= '0;
			err_q  <= bfi_pkg::ST_OK;
			full_q <= 1'b0;
		end else begin
			if (cmd.sweep_rst) sc_q <= '0;
			else if (cmd.init_clr || cmd.match_clr) sc_q <= sc_q + 1'b1;
			if (cmd.load) begin
				len_q  <= len_next;
				full_q <= load_full;
			end
			if (cmd.build_init) begin
				pc_q  <= '0;
				wa_q  <= '0;
				top_q <= '0;
				err_q <= bfi_pkg::ST_OK;
			end
			if (cmd.walk_dec) begin
				if (dec_open) begin
					if (nest_full) begin
						err_q <= bfi_pkg::ST_NEST;
					end else begin
						top_q <= top_q + 1'b1;
						wa_q  <= wa_q + 1'b1;
					end
				end else if (dec_close) begin
					top_q <= top_m1;
				end else begin
					wa_q <= wa_q + 1'b1;
				end
			end
			if (cmd.pop_b) wa_q <= wa_q + 1'b1;
			if (cmd.build_end && top_q != '0) err_q <= bfi_pkg::ST_OPEN;
			if (cmd.step_ex) begin
				pc_q <= nx_pc;
				tp_q <= nx_tp;
				if (set_bad) err_q <= bfi_pkg::ST_BAD;
			end
		end
	end

	// program store
	always_ff @(posedge clk) begin
		if (cmd.load && !load_full) prog_mem[len_q[AW-1:0]] <= it_byte_q;
		if (cmd.step_rd) prog_rd_q <= prog_mem[pc_q[AW-1:0]];
		else if (cmd.walk_rd) prog_rd_q <= prog_mem[wa_q[AW-1:0]];
	end

	// bracket match table
	always_ff @(posedge clk) begin
		if (init_match || cmd.match_clr) match_mem[sc_q[AW-1:0]] <= '0;
		else if (cmd.pop_a) match_mem[stk_rd_q] <= wa_q[AW-1:0];
		else if (cmd.pop_b) match_mem[wa_q[AW-1:0]] <= stk_rd_q;
		if (cmd.step_rd) match_rd_q <= match_mem[pc_q[AW-1:0]];
	end

	// tape
	always_ff @(posedge clk) begin
		if (init_tape) tape_mem[sc_q[TW-1:0]] <= 8'd0;
		else if (cmd.step_ex && tw_en) tape_mem[tp_q] <= tw_d;
		if (cmd.step_rd) tape_rd_q <= tape_mem[tp_q];
	end

	// bracket stack
	always_ff @(posedge clk) begin
		if (push_en) stk_mem[top_q[SW-1:0]] <= wa_q[AW-1:0];
		if (cmd.walk_dec && !dec_open && dec_close) stk_rd_q <= stk_mem[top_m1[SW-1:0]];
	end

	logic [16:0] len_w, pc_w;
	logic [2:0]  build_st;
	assign len_w = 17'(len_q);
	assign pc_w  = 17'(nx_pc);
	always_comb begin
		if (full_q) build_st = bfi_pkg::ST_FULL;
		else if (cmd.walk_dec) build_st = bfi_pkg::ST_NEST;
		else if (top_q != '0) build_st = bfi_pkg::ST_OPEN;
		else build_st = bfi_pkg::ST_OK;
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.load && !it_last_q) begin
			r_ov_q <= 1'b0;
			r_ob_q <= 8'd0;
			r_st_q <= load_full ? bfi_pkg::ST_FULL : err_q;
			r_pc_q <= 12'(17'(len_next));
		end
		if (cmd.build_end || (cmd.walk_dec && dec_open && nest_full)) begin
			r_ov_q <= 1'b0;
			r_ob_q <= 8'd0;
			r_st_q <= build_st;
			r_pc_q <= len_w[11:0];
		end
		if (cmd.step_ex) begin
			r_ov_q <= ex_ov;
			r_ob_q <= ex_ob;
			r_st_q <= ex_st;
			r_pc_q <= pc_w[11:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.push) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_out_valid    <= r_ov_q;
			out_out_byte     <= r_ob_q;
			out_status       <= r_st_q;
			out_prog_counter <= r_pc_q;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		stat.init_last  = (sc_q == CW'(CLR_N - 1));
		stat.match_last = (sc_q == CW'(PROG_DEPTH - 1));
		stat.item_cmd   = in_cmd;
		stat.item_last  = it_last_q;
		stat.walk_end   = (wa_q >= len_q);
		stat.dec_open   = dec_open;
		stat.dec_close  = dec_close;
		stat.nest_full  = nest_full;
		stat.slot_free  = !ov_q || out_ready;
	end

endmodule
`default_nettype wire

/* hw/rtl/brainfuck_interpreter_core.sv */
// Tape-machine core for the eight-instruction bracket language.
// in_ch carries one item per transfer: cmd 0 loads prog_byte at the next
// program address (load_last starts the bracket-table build), cmd 1
// executes one instruction, with in_byte used by the comma instruction.
// out_ch returns exactly one result per item: out_valid/out_byte for the
// period instruction, status, and the program counter after a step or
// the program length after a load or build. A step passes through
// accept, memory read, execute and output register; a plain load through
// accept, load and output register. A build clears the match table, then
// walks the program bytes with a pop for each matched close bracket, the
// walk set by the single program-store read port. One item is in flight
// at a time. After arst_n the core sweeps tape and match table to zero,
// one entry a cycle, with in_ch.ready low.
// The result sits in an output register; a new item is accepted while it
// waits, and the core holds the next result until out_ch.ready frees it.
`default_nettype none
module brainfuck_interpreter_core #(
	parameter int PROG_DEPTH = 4096,
	parameter int TAPE_DEPTH = 32768,
	parameter int NEST_DEPTH = 256
) (
	input wire         clk,
	input wire         arst_n,
	bfi_in_if.sink     in_ch,
	bfi_out_if.source  out_ch
);

	bfi_pkg::cmd_t  cmd;
	bfi_pkg::stat_t stat;

	bfi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfi_dpath #(
		.PROG_DEPTH (PROG_DEPTH),
		.TAPE_DEPTH (TAPE_DEPTH),
		.NEST_DEPTH (NEST_DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_cmd           (in_ch.cmd),
		.in_prog_byte     (in_ch.prog_byte),
		.in_load_last     (in_ch.load_last),
		.in_in_byte       (in_ch.in_byte),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.out_out_valid    (out_ch.out_valid),
		.out_out_byte     (out_ch.out_byte),
		.out_status       (out_ch.status),
		.out_prog_counter (out_ch.prog_counter)
	);

endmodule
`default_nettype wire
